### hw/rtl/heightmap_normal_stencil_defines.svh
// ----------------------------------------------------------------------------
// heightmap_normal_stencil assertion macros
// Shared property wrappers for the interface checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_NORMAL_STENCIL_DEFINES_SVH
`define HEIGHTMAP_NORMAL_STENCIL_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define HNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hns_pkg.sv
// ----------------------------------------------------------------------------
// hns_pkg
// Types and constants shared by the height-map normal stencil modules.
// ----------------------------------------------------------------------------
package hns_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GW_W       = 11;
  localparam int GH_W       = 16;
  localparam int RES_W      = 16;
  localparam int NORM_W     = 16;
  localparam int OUT_COL_W  = 10;
  localparam int ROW_W      = 16;
  localparam int SQ_W       = 30;
  localparam int SUM_W      = 62;
  localparam int ROOT_W     = 31;
  localparam int ROOT_TOP   = 60;
  localparam int DIV_W      = 47;
  localparam int QUO_W      = 16;
  localparam int FRAC_W     = 16;

  localparam int SQ_STEPS   = 4;
  localparam int ROOT_STEPS = 31;
  localparam int DIV_STEPS  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_RESOLUTION = 2'd2;

  localparam logic [GW_W-1:0]  GRID_WIDTH_RST      = 11'd1024;
  localparam logic [GH_W-1:0]  GRID_HEIGHT_RST     = 16'd1024;
  localparam logic [RES_W-1:0] CELL_RESOLUTION_RST = 16'd256;

  localparam logic [QUO_W-2:0] Q_MAX = 15'h7FFF;

  // result slots of one input, in emission order
  localparam logic [1:0] EMIT_UP_LEFT  = 2'd0;
  localparam logic [1:0] EMIT_UP_LAST  = 2'd1;
  localparam logic [1:0] EMIT_CUR_LEFT = 2'd2;
  localparam logic [1:0] EMIT_CUR_LAST = 2'd3;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       shift;
    logic       sq;
    logic       root_init;
    logic       root_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       present;
    logic       update;
    logic       last;
    logic [1:0] sel;
    logic [1:0] sq_idx;
    logic [1:0] comp;
  } hns_cmd_t;

  typedef struct packed {
    logic [3:0] en;
    logic       out_done;
  } hns_status_t;

endpackage

### hw/rtl/hns_ram.sv
// ----------------------------------------------------------------------------
// hns_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/hns_ctrl.sv
// ----------------------------------------------------------------------------
// hns_ctrl
// Sequencer: row read, per-result square/root/divide steps, output handoff.
// ----------------------------------------------------------------------------
module hns_ctrl import hns_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hns_status_t status,
  output hns_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_READ      = 4'd1;
  localparam logic [3:0] S_SEL       = 4'd2;
  localparam logic [3:0] S_LOAD      = 4'd3;
  localparam logic [3:0] S_SHIFT     = 4'd4;
  localparam logic [3:0] S_SQ        = 4'd5;
  localparam logic [3:0] S_ROOT_INIT = 4'd6;
  localparam logic [3:0] S_ROOT      = 4'd7;
  localparam logic [3:0] S_DIV_INIT  = 4'd8;
  localparam logic [3:0] S_DIV       = 4'd9;
  localparam logic [3:0] S_DIV_STORE = 4'd10;
  localparam logic [3:0] S_PRESENT   = 4'd11;
  localparam logic [3:0] S_WAIT      = 4'd12;
  localparam logic [3:0] S_UPDATE    = 4'd13;

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] emit, emit_next;
  logic [1:0] comp, comp_next;
  logic [3:0] later_mask;

  assign in_ready   = (state == S_IDLE);
  assign later_mask = 4'b1110 << emit;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    emit_next  = emit;
    comp_next  = comp;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        emit_next  = EMIT_UP_LEFT;
        state_next = S_SEL;
      end
      S_SEL: begin
        if (status.en[emit]) begin
          state_next = S_LOAD;
        end else if (emit == EMIT_CUR_LAST) begin
          state_next = S_UPDATE;
        end else begin
          emit_next = emit + 2'd1;
        end
      end
      S_LOAD: begin
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cnt_next   = '0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(SQ_STEPS - 1)) begin
          state_next = S_ROOT_INIT;
        end
      end
      S_ROOT_INIT: begin
        cnt_next   = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(ROOT_STEPS - 1)) begin
          comp_next  = COMP_X;
          state_next = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          state_next = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        if (comp == COMP_Z) begin
          state_next = S_PRESENT;
        end else begin
          comp_next  = comp + 2'd1;
          state_next = S_DIV_INIT;
        end
      end
      S_PRESENT: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (status.out_done) begin
          if (emit == EMIT_CUR_LAST) begin
            state_next = S_UPDATE;
          end else begin
            emit_next  = emit + 2'd1;
            state_next = S_SEL;
          end
        end
      end
      S_UPDATE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      emit  <= EMIT_UP_LEFT;
      comp  <= COMP_X;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      emit  <= emit_next;
      comp  <= comp_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == S_IDLE) && in_valid;
    cmd.load      = (state == S_LOAD);
    cmd.shift     = (state == S_SHIFT);
    cmd.sq        = (state == S_SQ);
    cmd.root_init = (state == S_ROOT_INIT);
    cmd.root_step = (state == S_ROOT);
    cmd.div_init  = (state == S_DIV_INIT);
    cmd.div_step  = (state == S_DIV);
    cmd.div_store = (state == S_DIV_STORE);
    cmd.present   = (state == S_PRESENT);
    cmd.update    = (state == S_UPDATE);
    cmd.last      = ((status.en & later_mask) == 4'd0);
    cmd.sel       = emit;
    cmd.sq_idx    = cnt[1:0];
    cmd.comp      = comp;
  end

endmodule

### hw/rtl/hns_datapath.sv
// ----------------------------------------------------------------------------
// hns_datapath
// Row stores, stencil window, config, shared multiply/root/divide units.
// ----------------------------------------------------------------------------
module hns_datapath import hns_pkg::*; #(
  parameter int MAX_WIDTH      = 1024,
  parameter int ELEVATION_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data,
  input  logic signed [ELEVATION_BITS-1:0] elevation,
  input  hns_cmd_t                         cmd,
  output hns_status_t                      status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [NORM_W-1:0]         normal_x,
  output logic signed [NORM_W-1:0]         normal_y,
  output logic signed [NORM_W-1:0]         normal_z,
  output logic [OUT_COL_W-1:0]             cell_column,
  output logic [ROW_W-1:0]                 cell_row,
  output logic                             last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EB = ELEVATION_BITS;
  localparam int DW = EB + 2;
  localparam int MW = (DW > SQ_W) ? DW : SQ_W;

  logic [GW_W-1:0]  grid_width;
  logic [GH_W-1:0]  grid_height;
  logic [RES_W-1:0] cell_resolution;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= GRID_WIDTH_RST;
      grid_height     <= GRID_HEIGHT_RST;
      cell_resolution <= CELL_RESOLUTION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:      grid_width      <= cfg_data[GW_W-1:0];
        REG_GRID_HEIGHT:     grid_height     <= cfg_data[GH_W-1:0];
        REG_CELL_RESOLUTION: cell_resolution <= cfg_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0]    wm1;
  logic [GH_W-1:0]  hm1;
  logic [CW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic             last_col, last_row, c1, c2, r1;

  always_comb begin
    if (grid_width == '0) begin
      wm1 = '0;
    end else if (32'(grid_width) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(grid_width - 11'd1);
    end
  end

  assign hm1      = (grid_height == '0) ? '0 : grid_height - 16'd1;
  assign last_col = (col_cnt >= wm1);
  assign last_row = (row_cnt >= hm1);
  assign c1       = (col_cnt != '0);
  assign c2       = (32'(col_cnt) >= 2);
  assign r1       = (row_cnt != '0);

  assign status.en = {last_row && last_col, last_row && c1, r1 && last_col, r1 && c1};
  assign status.out_done = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cmd.update) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + 16'd1;
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  logic signed [EB-1:0] v, old_rd, prev_rd;
  logic signed [EB-1:0] vq1, vq2, pq1, pq2, oq1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v <= elevation;
    end
    if (cmd.update) begin
      vq2 <= vq1;
      vq1 <= v;
      pq2 <= pq1;
      pq1 <= prev_rd;
      oq1 <= old_rd;
    end
  end

  hns_ram #(.WIDTH(EB), .DEPTH(MAX_WIDTH)) u_older_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (col_cnt),
    .wdata (prev_rd),
    .re    (cmd.capture),
    .raddr (col_cnt),
    .rdata (old_rd)
  );

  hns_ram #(.WIDTH(EB), .DEPTH(MAX_WIDTH)) u_prev_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (col_cnt),
    .wdata (v),
    .re    (cmd.capture),
    .raddr (col_cnt),
    .rdata (prev_rd)
  );

  // stencil neighbors for the selected result
  logic signed [EB-1:0] left, right, above, below;
  logic [CW-1:0]        em_col;
  logic [ROW_W-1:0]     em_row;

  always_comb begin
    case (cmd.sel)
      EMIT_UP_LEFT: begin
        left   = c2 ? pq2 : pq1;
        right  = prev_rd;
        above  = (row_cnt == 16'd1) ? pq1 : oq1;
        below  = vq1;
        em_col = col_cnt - CW'(1);
        em_row = row_cnt - 16'd1;
      end
      EMIT_UP_LAST: begin
        left   = c1 ? pq1 : prev_rd;
        right  = prev_rd;
        above  = (row_cnt == 16'd1) ? prev_rd : old_rd;
        below  = v;
        em_col = col_cnt;
        em_row = row_cnt - 16'd1;
      end
      EMIT_CUR_LEFT: begin
        left   = c2 ? vq2 : vq1;
        right  = v;
        above  = r1 ? pq1 : vq1;
        below  = vq1;
        em_col = col_cnt - CW'(1);
        em_row = row_cnt;
      end
      default: begin
        left   = c1 ? vq1 : v;
        right  = v;
        above  = r1 ? prev_rd : v;
        below  = v;
        em_col = col_cnt;
        em_row = row_cnt;
      end
    endcase
  end

  logic signed [DW-1:0] sx, sy;
  logic [DW-1:0]        ax, ay;
  logic                 dbl_x, dbl_y;

  assign dbl_x = (em_col == '0) || (em_col >= wm1);
  assign dbl_y = (em_row == '0) || (em_row >= hm1);

  always_comb begin
    sx = DW'(right) - DW'(left);
    sy = DW'(below) - DW'(above);
    if (dbl_x) begin
      sx = sx <<< 1;
    end
    if (dbl_y) begin
      sy = sy <<< 1;
    end
    ax = sx[DW-1] ? DW'(-sx) : DW'(sx);
    ay = sy[DW-1] ? DW'(-sy) : DW'(sy);
  end

  logic [MW-1:0]    mag_x, mag_y, mag_z, mag_or;
  logic             neg_x, neg_y;
  logic [CW-1:0]    res_col;
  logic [ROW_W-1:0] res_row;
  logic [5:0]       sh;

  assign mag_or = mag_x | mag_y | mag_z;

  // scale all three down together until each fits 30 bits
  always_comb begin
    sh = '0;
    for (int i = SQ_W; i < MW; i++) begin
      if (mag_or[i]) begin
        sh = 6'(i - SQ_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_x   <= MW'(ax);
      mag_y   <= MW'(ay);
      mag_z   <= MW'({cell_resolution, 1'b0});
      neg_x   <= sx[DW-1];
      neg_y   <= sy[DW-1];
      res_col <= em_col;
      res_row <= em_row;
    end else if (cmd.shift) begin
      mag_x <= mag_x >> sh;
      mag_y <= mag_y >> sh;
      mag_z <= mag_z >> sh;
    end
  end

  // sum of squares
  logic [SQ_W-1:0]   sq_a;
  logic [2*SQ_W-1:0] prod;
  logic [SUM_W-1:0]  acc;

  always_comb begin
    case (cmd.sq_idx)
      COMP_X:  sq_a = mag_x[SQ_W-1:0];
      COMP_Y:  sq_a = mag_y[SQ_W-1:0];
      COMP_Z:  sq_a = mag_z[SQ_W-1:0];
      default: sq_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      prod <= sq_a * sq_a;
      acc  <= (cmd.sq_idx == COMP_X) ? '0 : acc + SUM_W'(prod);
    end
  end

  // integer square root, one result bit per step
  logic [SUM_W-1:0] rrem, rres, rbit;
  logic [SUM_W:0]   rtry;
  logic [ROOT_W-1:0] m;

  assign rtry = {1'b0, rres} + {1'b0, rbit};
  assign m    = rres[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rrem <= acc;
      rres <= '0;
      rbit <= SUM_W'(1) << ROOT_TOP;
    end else if (cmd.root_step) begin
      if ({1'b0, rrem} >= rtry) begin
        rrem <= rrem - rtry[SUM_W-1:0];
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  // restoring divide: (mag * 2^16 + m) / (2 m)
  logic [SQ_W-1:0]  dmag;
  logic [DIV_W-1:0] drem, dsh;
  logic [QUO_W-1:0] quo;
  logic [QUO_W-2:0] qc;
  logic             dneg;
  logic [NORM_W-1:0] comp_val;

  always_comb begin
    case (cmd.comp)
      COMP_X: begin
        dmag = mag_x[SQ_W-1:0];
        dneg = neg_x;
      end
      COMP_Y: begin
        dmag = mag_y[SQ_W-1:0];
        dneg = neg_y;
      end
      default: begin
        dmag = mag_z[SQ_W-1:0];
        dneg = 1'b0;
      end
    endcase
    qc = (quo > {1'b0, Q_MAX}) ? Q_MAX : quo[QUO_W-2:0];
    if (m == '0) begin
      comp_val = '0;
    end else if (dneg) begin
      comp_val = NORM_W'(-{1'b0, qc});
    end else begin
      comp_val = {1'b0, qc};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem <= DIV_W'({dmag, {FRAC_W{1'b0}}}) + DIV_W'(m);
      dsh  <= DIV_W'({m, 1'b0}) << (DIV_STEPS - 1);
      quo  <= '0;
    end else if (cmd.div_step) begin
      if (drem >= dsh) begin
        drem <= drem - dsh;
        quo  <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo  <= {quo[QUO_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.comp)
        COMP_X:  normal_x <= comp_val;
        COMP_Y:  normal_y <= comp_val;
        default: normal_z <= comp_val;
      endcase
    end
    if (cmd.present) begin
      cell_column <= OUT_COL_W'(res_col);
      cell_row    <= res_row;
      last_of_run <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.present) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/heightmap_normal_stencil.sv
// ----------------------------------------------------------------------------
// heightmap_normal_stencil
// Streaming unit surface normals of a raster elevation grid.
// ----------------------------------------------------------------------------
// Elevation requests enter on in_valid/in_ready in raster order, one per cell.
// Normals leave on out_valid/out_ready, lagging one row and one column; the
// last row also emits its own cells, so one input causes zero to four
// results, the final one flagged by last_of_run.
// Config (grid_width, grid_height, cell_resolution) is written through
// cfg_we/cfg_index/cfg_data; the user writes it only while no request is in
// flight, and the block itself has no check that enforces it. Throughput: one
// request at a time. Each result runs a square sum on one multiplier, a 31-step
// root and three 16-step divides on a shared divider, and is held for as long
// as the receiver holds out_ready low. The sequencer waits on a stalled result
// before starting the next one; in_ready stays low until all results of the
// request are taken.
// Reset clears counters and handshake state and restores the default config;
// row store contents are undefined until the first row is written.
// ----------------------------------------------------------------------------
module heightmap_normal_stencil import hns_pkg::*; #(
  parameter int MAX_WIDTH      = 1024,
  parameter int ELEVATION_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ELEVATION_BITS-1:0] elevation,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [NORM_W-1:0]         normal_x,
  output logic signed [NORM_W-1:0]         normal_y,
  output logic signed [NORM_W-1:0]         normal_z,
  output logic [OUT_COL_W-1:0]             cell_column,
  output logic [ROW_W-1:0]                 cell_row,
  output logic                             last_of_run
);

  hns_cmd_t    cmd;
  hns_status_t status;

  hns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hns_datapath #(
    .MAX_WIDTH      (MAX_WIDTH),
    .ELEVATION_BITS (ELEVATION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .elevation   (elevation),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .last_of_run (last_of_run)
  );

endmodule

### hw/rtl/hns_checker.sv
// ----------------------------------------------------------------------------
// hns_checker
// Port-level checks for heightmap_normal_stencil, bound to the top level.
// ----------------------------------------------------------------------------
`include "heightmap_normal_stencil_defines.svh"

module hns_checker import hns_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [NORM_W-1:0] normal_x,
  input logic signed [NORM_W-1:0] normal_y,
  input logic signed [NORM_W-1:0] normal_z,
  input logic [OUT_COL_W-1:0]     cell_column,
  input logic [ROW_W-1:0]         cell_row,
  input logic                     last_of_run
);

  `HNS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(cell_column) && $stable(cell_row) && $stable(last_of_run), "stalled result changed")
  `HNS_ASSERT_NOW(a_ready_idle, in_ready, !out_valid, "request taken while a result is pending")
  `HNS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken too early")
  `HNS_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !last_of_run, !in_ready, "run ended before last result")
  `HNS_ASSERT_NOW(a_z_positive, out_valid, !normal_z[NORM_W-1], "negative z component")

endmodule

bind heightmap_normal_stencil hns_checker u_hns_checker (.*);

### sim/heightmap_normal_stencil_tb.sv
// ----------------------------------------------------------------------------
// heightmap_normal_stencil_tb
// Self-checking testbench for the height-map surface normal stencil.
// ----------------------------------------------------------------------------
// Streams whole elevation frames through the block and predicts every normal
// (central differences, border doubling, Q1.15 normalization) in the bench.
// Each result is checked field by field, in order. Frames cover extreme
// values, degenerate grid sizes, a count left past a shrunken height,
// wide rows, a long receiver hold-off and random frames.
// Both handshakes idle at random.
// ----------------------------------------------------------------------------
module heightmap_normal_stencil_tb;
  import hns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_CAP = 1024;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [9:0]         col;
    logic [15:0]        row;
    logic               last;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] elevation = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [9:0] cell_column;
  logic [15:0] cell_row;
  logic last_of_run;

  heightmap_normal_stencil dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .elevation(elevation),
    .out_valid(out_valid), .out_ready(out_ready), .normal_x(normal_x),
    .normal_y(normal_y), .normal_z(normal_z), .cell_column(cell_column),
    .cell_row(cell_row), .last_of_run(last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bench copy of block state
  logic signed [23:0] older_row [ROW_CAP];
  logic signed [23:0] prev_row [ROW_CAP];
  logic signed [23:0] up_left;
  int unsigned col_cnt, row_cnt;
  logic [10:0] gw;
  logic [15:0] gh, res;

  normal_t pending_normals[$];
  int errors = 0;
  int items_sent = 0;
  int normals_seen = 0;
  int frames_sent = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  int stall_pct = 0;

  function automatic int unsigned width_eff();
    if (gw == 0) return 1;
    if (gw > ROW_CAP) return ROW_CAP;
    return gw;
  endfunction

  function automatic int unsigned height_eff();
    return (gh == 0) ? 1 : gh;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] scale_comp(bit neg, longint unsigned mag,
                                             longint unsigned m);
    longint unsigned q;
    logic [15:0] qs;
    q = (mag * 65536 + m) / (2 * m);
    if (q > 32767) q = 32767;
    qs = q[15:0];
    return neg ? -qs : qs;
  endfunction

  function automatic normal_t surface_normal(longint left, longint right, longint above,
                                             longint below, int unsigned col,
                                             int unsigned row);
    normal_t n;
    longint sx, sy;
    longint unsigned ax, ay, az, m;
    sx = right - left;
    sy = below - above;
    if (col == 0 || col >= width_eff() - 1) sx *= 2;
    if (row == 0 || row >= height_eff() - 1) sy *= 2;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = 2 * longint'(res);
    while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30) || az >= (64'd1 << 30)) begin
      ax >>= 1; ay >>= 1; az >>= 1;
    end
    m = int_sqrt(ax * ax + ay * ay + az * az);
    n = '0;
    if (m != 0) begin
      n.nx = scale_comp(sx < 0, ax, m);
      n.ny = scale_comp(sy < 0, ay, m);
      n.nz = scale_comp(1'b0, az, m);
    end
    n.col = col[9:0];
    n.row = row[15:0];
    return n;
  endfunction

  function automatic void predict_normals(logic signed [23:0] v);
    int unsigned w, h, r, c;
    bit last_col, last_row;
    longint mid, left, above;
    normal_t batch[$];
    w = width_eff(); h = height_eff(); r = row_cnt; c = col_cnt;
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    if (r >= 1) begin
      if (c >= 1) begin
        mid = older_row[c-1];
        left = (c >= 2) ? longint'(older_row[c-2]) : mid;
        above = (r == 1) ? mid : longint'(up_left);
        batch = {batch, surface_normal(left, prev_row[c], above, prev_row[c-1], c - 1, r - 1)};
      end
      if (last_col) begin
        mid = prev_row[c];
        left = (c >= 1) ? longint'(older_row[c-1]) : mid;
        above = (r == 1) ? mid : longint'(older_row[c]);
        batch = {batch, surface_normal(left, mid, above, v, c, r - 1)};
      end
    end
    if (last_row) begin
      if (c >= 1) begin
        mid = prev_row[c-1];
        left = (c >= 2) ? longint'(prev_row[c-2]) : mid;
        above = (r == 0) ? mid : longint'(older_row[c-1]);
        batch = {batch, surface_normal(left, v, above, mid, c - 1, r)};
      end
      if (last_col) begin
        left = (c >= 1) ? longint'(prev_row[c-1]) : v;
        above = (r == 0) ? longint'(v) : longint'(prev_row[c]);
        batch = {batch, surface_normal(left, v, above, v, c, r)};
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_normals = {pending_normals, batch[i]};
    up_left = older_row[c];
    older_row[c] = prev_row[c];
    prev_row[c] = v;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  task automatic send_elevation(logic signed [23:0] v);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    elevation = v;
    do @(posedge clk); while (!in_ready);
    predict_normals(v);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // drains outstanding normals, then covers the no-result latency
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_normals.size() > 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_GRID_WIDTH:      gw = val[10:0];
      REG_GRID_HEIGHT:     gh = val;
      REG_CELL_RESOLUTION: res = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [15:0] w, logic [15:0] h, logic [15:0] r);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_CELL_RESOLUTION, r);
  endtask

  function automatic logic signed [23:0] rand_elev();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return 24'(int'($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  task automatic send_frame(int n, bit extremes);
    for (int i = 0; i < n; i++)
      send_elevation(extremes ? ((i % 3 == 0) ? 24'sh7FFFFF : 24'sh800000) : rand_elev());
    frames_sent++;
    wait_idle();
  endtask

  task automatic test_extreme_values();
    set_grid(16'd4, 16'd3, 16'd1);
    send_frame(12, 1'b1);
    // flat cells with zero resolution give the zero vector
    set_grid(16'd2, 16'd2, 16'd0);
    for (int i = 0; i < 4; i++) send_elevation(24'sd1234);
    frames_sent++;
    wait_idle();
  endtask

  task automatic test_degenerate_sizes();
    set_grid(16'd0, 16'd0, 16'd65535);
    send_frame(1, 1'b0);
    set_grid(16'd1, 16'd3, 16'd256);
    send_frame(3, 1'b0);
    set_grid(16'd3, 16'd1, 16'd77);
    send_frame(3, 1'b1);
  endtask

  task automatic test_count_past_height();
    set_grid(16'd2, 16'd65535, 16'd300);
    for (int i = 0; i < 6; i++) send_elevation(rand_elev());
    wait_idle();
    // row count now sits past the new last row
    write_reg(REG_GRID_HEIGHT, 16'd2);
    send_frame(2, 1'b0);
    write_reg(REG_GRID_HEIGHT, 16'd0);
    send_frame(2, 1'b0);
  endtask

  task automatic test_wide_rows();
    set_grid(16'd64, 16'd2, 16'd65535);
    send_frame(128, 1'b0);
  endtask

  task automatic test_receiver_holdoff();
    set_grid(16'd8, 16'd4, 16'd128);
    hold_cycles = 400;
    send_frame(32, 1'b0);
  endtask

  task automatic test_random_frames();
    int w, h, target;
    target = items_sent + 200;
    while (items_sent < target) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 4))
        0: set_grid(16'(w), 16'(h), 16'd0);
        1: set_grid(16'(w), 16'(h), 16'd65535);
        default: set_grid(16'(w), 16'(h), 16'($urandom_range(1, 1024)));
      endcase
      send_frame(w * h, 1'b0);
    end
  endtask

  // receiver: long hold-off on request, otherwise a drifting stall rate
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      if ($urandom_range(0, 63) == 0)
        stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    normal_t exp_n;
    if (!rst && out_valid && out_ready) begin
      normals_seen++;
      if (pending_normals.size() == 0) begin
        $error("unexpected normal at col %0d row %0d", cell_column, cell_row);
        errors++;
      end else begin
        exp_n = pending_normals.pop_front();
        if (normal_x !== exp_n.nx) begin
          $error("normal_x exp %0d got %0d", exp_n.nx, normal_x); errors++;
        end
        if (normal_y !== exp_n.ny) begin
          $error("normal_y exp %0d got %0d", exp_n.ny, normal_y); errors++;
        end
        if (normal_z !== exp_n.nz) begin
          $error("normal_z exp %0d got %0d", exp_n.nz, normal_z); errors++;
        end
        if (cell_column !== exp_n.col) begin
          $error("cell_column exp %0d got %0d", exp_n.col, cell_column); errors++;
        end
        if (cell_row !== exp_n.row) begin
          $error("cell_row exp %0d got %0d", exp_n.row, cell_row); errors++;
        end
        if (last_of_run !== exp_n.last) begin
          $error("last_of_run exp %0d got %0d", exp_n.last, last_of_run); errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("timeout with %0d normals outstanding", pending_normals.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    gw = GRID_WIDTH_RST;
    gh = GRID_HEIGHT_RST;
    res = CELL_RESOLUTION_RST;
    col_cnt = 0;
    row_cnt = 0;
    up_left = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extreme_values();
    test_degenerate_sizes();
    test_count_past_height();
    test_wide_rows();
    test_receiver_holdoff();
    test_random_frames();
    wait_idle();
    if (pending_normals.size() > 0) begin
      $error("%0d normals never arrived", pending_normals.size());
      errors++;
    end
    $display("covered %0d elevation requests in %0d frames, %0d normals checked",
             items_sent, frames_sent, normals_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/hns_pkg.sv
hw/rtl/hns_ram.sv
hw/rtl/hns_ctrl.sv
hw/rtl/hns_datapath.sv
hw/rtl/heightmap_normal_stencil.sv
hw/rtl/hns_checker.sv
sim/heightmap_normal_stencil_tb.sv
